### rtl/rlbd_pkg.sv
`default_nettype none

package rlbd_pkg;

    // Field widths fixed by the register map and the channel payloads
    localparam int SAMPLE_BITS    = 10;
    localparam int MASK_BITS      = 8;
    localparam int COUNT_BITS     = 4;
    localparam int TICK_BITS      = 16;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 40;
    localparam int WINDOW_REGS    = 4;
    localparam int WINDOW_BITS    = 4 * SAMPLE_BITS;

    // Register reset values
    localparam logic [TICK_BITS-1:0]   DEBOUNCE_RESET  = TICK_BITS'(50);
    localparam logic [SAMPLE_BITS-1:0] THRESHOLD_RESET = SAMPLE_BITS'(50);

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_BUTTON_COUNT     = 3'd0,
        CFG_DEBOUNCE_TICKS   = 3'd1,
        CFG_CHANGE_THRESHOLD = 3'd2,
        CFG_WINDOWS_0_1      = 3'd3,
        CFG_WINDOWS_2_3      = 3'd4,
        CFG_WINDOWS_4_5      = 3'd5,
        CFG_WINDOWS_6_7      = 3'd6
    } cfg_index_t;

    typedef logic [SAMPLE_BITS-1:0] sample_t;
    typedef logic [MASK_BITS-1:0]   mask_t;

endpackage

`default_nettype wire

### rtl/rlbd_sample_if.sv
`default_nettype none

interface rlbd_sample_if;
    import rlbd_pkg::*;

    logic    valid;
    logic    ready;
    sample_t adc_sample;

    modport source (output valid, output adc_sample, input ready);
    modport sink (input valid, input adc_sample, output ready);
endinterface

`default_nettype wire

### rtl/rlbd_result_if.sv
`default_nettype none

interface rlbd_result_if;
    import rlbd_pkg::*;

    logic    valid;
    logic    ready;
    mask_t   held_mask;
    mask_t   pressed_mask;
    mask_t   released_mask;
    sample_t raw_level;

    modport source (
        output valid, output held_mask, output pressed_mask,
        output released_mask, output raw_level, input ready
    );
    modport sink (
        input valid, input held_mask, input pressed_mask,
        input released_mask, input raw_level, output ready
    );
endinterface

`default_nettype wire

### rtl/resistor_ladder_button_decoder.sv
`default_nettype none

// A sample beat is registered in the sample register, then its result in the result register.
// Throughput: one sample per cycle while the result sink keeps ready high; the sample
//   register and the result register advance together, so the window match, the change
//   filter and the state update all sit as combinational logic between them.
// Reset (rst_n low, asynchronous): state and counter clear, registers take their
//   reset values (debounce 50, threshold 50, no buttons, empty windows).
module resistor_ladder_button_decoder #(
    parameter int MAX_BUTTONS = 8
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rlbd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [rlbd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    rlbd_sample_if.sink                             sample,
    rlbd_result_if.source                           result
);
    import rlbd_pkg::*;

    localparam logic [COUNT_BITS-1:0] MaxCount = COUNT_BITS'(MAX_BUTTONS);

    // Configuration registers
    logic [COUNT_BITS-1:0]  button_count_reg;
    logic [TICK_BITS-1:0]   debounce_reg;
    sample_t                threshold_reg;
    logic [WINDOW_BITS-1:0] windows_reg [WINDOW_REGS];

    // Decoder state
    mask_t                  held_reg;
    mask_t                  press_reg;
    mask_t                  release_reg;
    sample_t                accepted_reg;
    logic [TICK_BITS-1:0]   ticks_reg;

    // Pipeline registers
    logic                   s1_valid_reg;
    sample_t                s1_sample_reg;
    logic                   out_valid_reg;
    mask_t                  out_held_reg;
    mask_t                  out_press_reg;
    mask_t                  out_release_reg;
    sample_t                out_level_reg;

    logic                   advance;
    logic                   process;
    logic [COUNT_BITS-1:0]  count;
    mask_t                  use_mask;
    mask_t                  hit;
    mask_t                  match;
    sample_t                diff;
    logic                   evaluate;
    logic                   take_sample;
    logic                   held_change;

    mask_t                  held_next;
    mask_t                  press_next;
    mask_t                  release_next;
    sample_t                accepted_next;
    logic [TICK_BITS-1:0]   ticks_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            button_count_reg <= '0;
            debounce_reg     <= DEBOUNCE_RESET;
            threshold_reg    <= THRESHOLD_RESET;
            for (int r = 0; r < WINDOW_REGS; r++) begin
                windows_reg[r] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_BUTTON_COUNT:     button_count_reg <= cfg_data[COUNT_BITS-1:0];
                CFG_DEBOUNCE_TICKS:   debounce_reg     <= cfg_data[TICK_BITS-1:0];
                CFG_CHANGE_THRESHOLD: threshold_reg    <= cfg_data[SAMPLE_BITS-1:0];
                CFG_WINDOWS_0_1:      windows_reg[0]   <= cfg_data[WINDOW_BITS-1:0];
                CFG_WINDOWS_2_3:      windows_reg[1]   <= cfg_data[WINDOW_BITS-1:0];
                CFG_WINDOWS_4_5:      windows_reg[2]   <= cfg_data[WINDOW_BITS-1:0];
                CFG_WINDOWS_6_7:      windows_reg[3]   <= cfg_data[WINDOW_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the whole pipe moves when the result slot is free or drains
    assign advance      = !out_valid_reg || result.ready;
    assign sample.ready = advance || !s1_valid_reg;
    assign process      = s1_valid_reg && advance;

    // Clamp the button count and build the in-use mask
    assign count = (button_count_reg > MaxCount) ? MaxCount : button_count_reg;

    always_comb begin
        for (int i = 0; i < MASK_BITS; i++) begin
            use_mask[i] = COUNT_BITS'(i) < count;
        end
    end

    // Window comparators, one per supported button
    genvar g;
    generate
        for (g = 0; g < MASK_BITS; g++) begin : g_window
            if (g < MAX_BUTTONS) begin : g_cmp
                localparam int Reg  = g / 2;
                localparam int Base = (g % 2) * 2 * SAMPLE_BITS;
                sample_t lo;
                sample_t hi;
                assign lo = windows_reg[Reg][Base +: SAMPLE_BITS];
                assign hi = windows_reg[Reg][Base + SAMPLE_BITS +: SAMPLE_BITS];
                assign hit[g] = use_mask[g] && (s1_sample_reg >= lo)
                                && (s1_sample_reg <= hi);
            end else begin : g_none
                assign hit[g] = 1'b0;
            end
        end
    endgenerate

    // Keep only the lowest matching window
    assign match = hit & (~hit + mask_t'(1));

    // Change filter and edge detection
    assign diff = (s1_sample_reg > accepted_reg) ? s1_sample_reg - accepted_reg
                                                 : accepted_reg - s1_sample_reg;
    assign evaluate    = ticks_reg >= debounce_reg;
    assign take_sample = evaluate && (diff >= threshold_reg);
    assign held_change = take_sample && (match != held_reg);

    always_comb begin
        held_next     = held_reg;
        press_next    = press_reg;
        release_next  = release_reg;
        accepted_next = accepted_reg;
        ticks_next    = (ticks_reg == '1) ? ticks_reg : ticks_reg + TICK_BITS'(1);
        if (evaluate) begin
            press_next   = '0;
            release_next = '0;
        end
        if (take_sample) begin
            accepted_next = s1_sample_reg;
        end
        if (held_change) begin
            held_next    = match;
            press_next   = match & ~held_reg;
            release_next = held_reg & ~match;
            ticks_next   = '0;
        end
    end

    // Advance state on each processed beat
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            held_reg     <= '0;
            press_reg    <= '0;
            release_reg  <= '0;
            accepted_reg <= '0;
            ticks_reg    <= '0;
        end else if (process) begin
            held_reg     <= held_next;
            press_reg    <= press_next;
            release_reg  <= release_next;
            accepted_reg <= accepted_next;
            ticks_reg    <= ticks_next;
        end
    end

    // Pipeline valid bits
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (sample.ready) begin
                s1_valid_reg <= sample.valid;
            end
            if (advance) begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // Hold sample and result payloads
    always_ff @(posedge clk) begin
        if (sample.valid && sample.ready) begin
            s1_sample_reg <= sample.adc_sample;
        end
        if (process) begin
            out_held_reg    <= held_next & use_mask;
            out_press_reg   <= press_next & use_mask;
            out_release_reg <= release_next & use_mask;
            out_level_reg   <= accepted_next;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.held_mask     = out_held_reg;
    assign result.pressed_mask  = out_press_reg;
    assign result.released_mask = out_release_reg;
    assign result.raw_level     = out_level_reg;

    // A change of the held button restarts the hold-off
    a_ticks_restart: assert property (@(posedge clk) disable iff (!rst_n)
        process && held_change |=> ticks_reg == '0)
        else $error("hold-off counter not restarted after a held change");

    // The held mask never names more than one button
    a_held_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(held_reg))
        else $error("held state not one-hot");

    // A button is never pressed and released in the same beat
    a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_press_reg & out_release_reg) == '0)
        else $error("press and release overlap");

    // An empty result slot never blocks the input
    a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> sample.ready)
        else $error("input stalled with empty result slot");

    // State moves only when a beat is processed
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !process |=> $stable(held_reg) && $stable(accepted_reg))
        else $error("state changed without a processed beat");

endmodule

`default_nettype wire
